// File: rtl/wpq_pkg.sv
// wpq_pkg: shared types, widths and codes of the weighted pick block
// no dependencies; imported by wpq_mod, the top block and the checker
package wpq_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int ID_W    = 10;
    localparam int WGT_W   = 12;
    localparam int LIM_W   = 11;
    localparam int RND_W   = 32;
    localparam int ST_W    = 2;
    localparam int TOT_W   = 16;
    localparam int NCFG_W  = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

    localparam logic [ST_W-1:0] ST_PICKED    = 2'd0;
    localparam logic [ST_W-1:0] ST_DEFAULT   = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [ST_W-1:0] ST_SETUP     = 2'd3;

    // register select is paddr[2]
    localparam logic REG_ENTRIES   = 1'b0;
    localparam logic REG_EMPTY_DEF = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [WGT_W-1:0] weight;
        logic [LIM_W-1:0] limit;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_MOD,
        S_WALK
    } t_state;

endpackage

// File: rtl/wpq_ram.sv
// wpq_ram: generic single-write, single-read synchronous ram
// read data is registered; no dependencies
module wpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wpq_mod.sv
// wpq_mod: bit-serial remainder of a 32-bit word by a 16-bit divisor
// one restoring step per cycle; depends on wpq_pkg
module wpq_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wpq_pkg::RND_W-1:0] i_dividend,
    input  logic [wpq_pkg::TOT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [wpq_pkg::TOT_W-1:0] o_rem
);
    import wpq_pkg::*;

    localparam int STEP_W = $clog2(RND_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TOT_W-1:0]  r_rem;
    logic [RND_W-1:0]  r_dvd;
    logic [TOT_W-1:0]  r_div;
    logic [TOT_W:0]    trial;
    logic [TOT_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[RND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = TOT_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[TOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(RND_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/weighted_pick_with_use_quotas.sv
// weighted_pick_with_use_quotas: roulette-wheel pick over a slot table with use quotas
// depends on wpq_pkg, wpq_ram (slot table and use counters) and wpq_mod
//
// An item is taken when start is high and busy is low; its single result shows for
// one cycle with o_done and cannot be held off by the receiver. A load or an unused
// operation answers in the next cycle. A restart sweeps the slot memory one slot a
// cycle, over the configured entry count clipped to ENTRIES, and answers when the
// sweep is done (in the next cycle when that count is zero). A draw runs the
// bit-serial remainder unit, then walks the slot memory one slot a cycle until the
// pick is found or the walk runs off the end. An empty or defaulted draw answers in
// the next cycle.
module weighted_pick_with_use_quotas (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [wpq_pkg::OP_W-1:0]    i_operation,
    input  logic [wpq_pkg::SLOT_W-1:0]  i_slot_index,
    input  logic [wpq_pkg::ID_W-1:0]    i_entry_id,
    input  logic [wpq_pkg::WGT_W-1:0]   i_entry_weight,
    input  logic signed [wpq_pkg::LIM_W-1:0] i_entry_max_uses,
    input  logic [wpq_pkg::RND_W-1:0]   i_random_word,
    output logic                        o_done,
    output logic [wpq_pkg::ST_W-1:0]    o_status,
    output logic [wpq_pkg::ID_W-1:0]    o_chosen_id,
    output logic [wpq_pkg::SLOT_W-1:0]  o_chosen_slot,
    output logic [wpq_pkg::TOT_W-1:0]   o_remaining_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpq_pkg::PADDR_W-1:0] paddr,
    input  logic [wpq_pkg::PDATA_W-1:0] pwdata,
    output logic [wpq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import wpq_pkg::*;

    // configuration
    logic [NCFG_W-1:0] r_cfg_entries;
    logic              r_cfg_empty_def;

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_rd_valid, n_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [TOT_W-1:0]   r_pick, n_pick;
    logic [ENTRIES-1:0] r_live, n_live;
    logic               r_done, n_done;
    logic [ST_W-1:0]    r_status, n_status;
    logic [ID_W-1:0]    r_id, n_id;
    logic [SLOT_W-1:0]  r_slot, n_slot;

    logic               accept;
    logic               issue;
    logic               last_sweep;
    logic               last_walk;
    logic [CNT_W-1:0]   clip_n;
    logic [IDX_W+SLOT_W-1:0] load_ext;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [TOT_W:0]     sum_ext;
    logic [TOT_W-1:0]   sum_sat;
    logic [TOT_W-1:0]   wgt_ext;
    logic [LIM_W-1:0]   uses_dec;

    // memory ports
    logic               we_slot;
    t_slot              wdata_slot;
    t_slot              slot_q;
    logic               we_uses;
    logic [LIM_W-1:0]   wdata_uses;
    logic [LIM_W-1:0]   uses_q;

    // remainder unit
    logic               mod_start;
    logic               mod_done;
    logic [TOT_W-1:0]   mod_rem;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_entries   <= '0;
            r_cfg_empty_def <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_ENTRIES) begin
                r_cfg_entries <= pwdata[NCFG_W-1:0];
            end else begin
                r_cfg_empty_def <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_EMPTY_DEF) ? PDATA_W'(r_cfg_empty_def)
                                                : PDATA_W'(r_cfg_entries);
    assign pready = 1'b1;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign issue = ((r_state == S_SWEEP) && (r_idx < r_n)) ||
                   ((r_state == S_WALK) && (r_idx < CNT_W'(ENTRIES)));

    assign clip_n = (32'(r_cfg_entries) > ENTRIES) ? CNT_W'(ENTRIES)
                                                   : CNT_W'(r_cfg_entries);

    assign last_sweep = ((CNT_W'(r_rd_idx) + 1'b1) == r_n);
    assign last_walk  = (r_rd_idx == IDX_W'(ENTRIES - 1));

    assign load_ext = {IDX_W'(0), i_slot_index};
    assign slot_ext = {SLOT_W'(0), r_rd_idx};

    assign wgt_ext  = TOT_W'(slot_q.weight);
    assign sum_ext  = {1'b0, r_total} + (TOT_W + 1)'(slot_q.weight);
    assign sum_sat  = sum_ext[TOT_W] ? '1 : sum_ext[TOT_W-1:0];
    assign uses_dec = uses_q - 1'b1;

    assign we_slot    = accept && (i_operation == OP_LOAD) &&
                        (32'(i_slot_index) < ENTRIES);
    assign wdata_slot = '{id: i_entry_id, weight: i_entry_weight,
                          limit: i_entry_max_uses};

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_n        = r_n;
        n_rd_valid = issue;
        n_rd_idx   = r_idx[IDX_W-1:0];
        n_total    = r_total;
        n_pick     = r_pick;
        n_live     = r_live;
        n_done     = 1'b0;
        n_status   = r_status;
        n_id       = r_id;
        n_slot     = r_slot;
        we_uses    = 1'b0;
        wdata_uses = uses_q;
        mod_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id   = '0;
                    n_slot = '0;
                    case (i_operation)
                        OP_RESTART: begin
                            n_live  = '0;
                            n_total = '0;
                            n_idx   = '0;
                            n_n     = clip_n;
                            if (clip_n == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_SETUP;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        OP_DRAW: begin
                            if (r_cfg_entries == '0 && r_cfg_empty_def) begin
                                n_done   = 1'b1;
                                n_status = ST_DEFAULT;
                            end else if (r_total == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_EXHAUSTED;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                        default: begin
                            // load and the unused code just acknowledge
                            n_done   = 1'b1;
                            n_status = ST_SETUP;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_valid) begin
                    we_uses            = 1'b1;
                    wdata_uses         = slot_q.limit;
                    n_live[r_rd_idx]   = 1'b1;
                    n_total            = sum_sat;
                    if (last_sweep) begin
                        n_done   = 1'b1;
                        n_status = ST_SETUP;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_pick  = mod_rem;
                    n_idx   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_valid && r_live[r_rd_idx] && (r_pick < wgt_ext)) begin
                    n_done   = 1'b1;
                    n_status = ST_PICKED;
                    n_id     = slot_q.id;
                    n_slot   = slot_ext[SLOT_W-1:0];
                    n_state  = S_IDLE;
                    // a positive count is a quota; zero or negative is unlimited
                    if (uses_q != '0 && !uses_q[LIM_W-1]) begin
                        we_uses    = 1'b1;
                        wdata_uses = uses_dec;
                        if (uses_dec == '0) begin
                            n_live[r_rd_idx] = 1'b0;
                            n_total = (r_total >= wgt_ext) ? (r_total - wgt_ext) : '0;
                        end
                    end
                end else if (r_rd_valid) begin
                    if (r_live[r_rd_idx]) begin
                        n_pick = r_pick - wgt_ext;
                    end
                    if (last_walk) begin
                        // walk ran off the end after a weight changed under a live table
                        n_done   = 1'b1;
                        n_status = ST_EXHAUSTED;
                        n_id     = '0;
                        n_slot   = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
            r_live     <= '0;
            r_total    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
            r_live     <= n_live;
            r_total    <= n_total;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_rd_idx <= n_rd_idx;
        r_pick   <= n_pick;
        r_status <= n_status;
        r_id     <= n_id;
        r_slot   <= n_slot;
    end

    wpq_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we_slot),
        .i_waddr (load_ext[IDX_W-1:0]),
        .i_wdata (wdata_slot),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (slot_q)
    );

    wpq_ram #(
        .WIDTH (LIM_W),
        .DEPTH (ENTRIES)
    ) u_uses_ram (
        .i_clk   (i_clk),
        .i_we    (we_uses),
        .i_waddr (r_rd_idx),
        .i_wdata (wdata_uses),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (uses_q)
    );

    wpq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_random_word),
        .i_divisor  (r_total),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_chosen_id       = r_id;
    assign o_chosen_slot     = r_slot;
    assign o_remaining_total = r_total;

endmodule

// File: rtl/wpq_checker.sv
// wpq_checker: port-level checks of the weighted pick block
// depends on wpq_pkg; bound to weighted_pick_with_use_quotas below
module wpq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [wpq_pkg::ST_W-1:0]   o_status,
    input logic [wpq_pkg::ID_W-1:0]   o_chosen_id,
    input logic [wpq_pkg::SLOT_W-1:0] o_chosen_slot
);
    import wpq_pkg::*;

    // an accepted beat either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_done || busy)
        else $error("accepted beat neither answered nor busy");

    // leaving busy always delivers the result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("busy dropped without a result");

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while still busy");

    // non-pick answers carry no slot
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_PICKED) |-> (o_chosen_id == '0) && (o_chosen_slot == '0))
        else $error("non-pick result with nonzero id or slot");

endmodule

bind weighted_pick_with_use_quotas wpq_checker u_wpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_chosen_id   (o_chosen_id),
    .o_chosen_slot (o_chosen_slot)
);

// File: sim/tb.sv
// tb: self-checking bench for weighted_pick_with_use_quotas
// needs wpq_pkg and the rtl of the block; drives items, apb register writes, checks picks

module tb;
    import wpq_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_ENTRIES   = {REG_ENTRIES, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_EMPTY_DEF = {REG_EMPTY_DEF, 2'b00};
    localparam logic [OP_W-1:0]    OP_SPARE       = 2'd3;
    localparam logic [LIM_W-1:0]   LIM_FOREVER    = '1;
    localparam int                 RANDOM_ITEMS   = 950;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic [TOT_W-1:0]  total;
    } pick_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation = '0;
    logic [SLOT_W-1:0]   i_slot_index = '0;
    logic [ID_W-1:0]     i_entry_id = '0;
    logic [WGT_W-1:0]    i_entry_weight = '0;
    logic [LIM_W-1:0]    i_entry_max_uses = '0;
    logic [RND_W-1:0]    i_random_word = '0;
    logic                o_done;
    logic [ST_W-1:0]     o_status;
    logic [ID_W-1:0]     o_chosen_id;
    logic [SLOT_W-1:0]   o_chosen_slot;
    logic [TOT_W-1:0]    o_remaining_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    weighted_pick_with_use_quotas i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .i_entry_id       (i_entry_id),
        .i_entry_weight   (i_entry_weight),
        .i_entry_max_uses (i_entry_max_uses),
        .i_random_word    (i_random_word),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_chosen_id      (o_chosen_id),
        .o_chosen_slot    (o_chosen_slot),
        .o_remaining_total(o_remaining_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    class quota_wheel_sb;
        logic [ID_W-1:0]   ids     [ENTRIES];
        logic [WGT_W-1:0]  weights [ENTRIES];
        logic [LIM_W-1:0]  limits  [ENTRIES];
        logic [LIM_W-1:0]  uses    [ENTRIES];
        bit                live    [ENTRIES];
        logic [TOT_W-1:0]  live_total;
        logic [NCFG_W-1:0] slots_cfg;
        bit                empty_default;
        pick_t             owed_picks[$];
        int                mismatches;

        function new();
            foreach (ids[i]) begin
                ids[i] = '0;
                weights[i] = '0;
                limits[i] = '0;
                uses[i] = '0;
                live[i] = 1'b0;
            end
            live_total = '0;
            slots_cfg = '0;
            empty_default = 1'b1;
            mismatches = 0;
        endfunction

        task report(input string what);
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t mismatch: %s", $time, what);
            end
        endtask

        function int pending();
            return owed_picks.size();
        endfunction

        function void set_config(input logic [PADDR_W-1:0] addr,
                                 input logic [PDATA_W-1:0] data);
            if (addr == ADDR_ENTRIES) begin
                slots_cfg = data[NCFG_W-1:0];
            end else if (addr == ADDR_EMPTY_DEF) begin
                empty_default = data[0];
            end
        endfunction

        function void note_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                                input logic [ID_W-1:0] id, input logic [WGT_W-1:0] wgt,
                                input logic [LIM_W-1:0] lim, input logic [RND_W-1:0] rnd);
            pick_t       ans;
            int unsigned span;
            int unsigned sum;
            int unsigned pick;
            bit          found;
            ans = '0;
            ans.status = ST_SETUP;
            case (op)
                OP_LOAD: begin
                    ids[idx] = id;
                    weights[idx] = wgt;
                    limits[idx] = lim;
                end
                OP_RESTART: begin
                    span = (slots_cfg > ENTRIES) ? ENTRIES : slots_cfg;
                    sum = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (i < span) begin
                            live[i] = 1'b1;
                            uses[i] = limits[i];
                            sum += weights[i];
                            if (sum > 32'hFFFF) sum = 32'hFFFF;
                        end else begin
                            live[i] = 1'b0;
                            uses[i] = '0;
                        end
                    end
                    live_total = TOT_W'(sum);
                end
                OP_DRAW: begin
                    if (slots_cfg == 0 && empty_default) begin
                        ans.status = ST_DEFAULT;
                    end else if (live_total == 0) begin
                        ans.status = ST_EXHAUSTED;
                    end else begin
                        // walk falls off the end when a load shrank a live weight
                        ans.status = ST_EXHAUSTED;
                        pick = rnd % live_total;
                        found = 1'b0;
                        for (int i = 0; i < ENTRIES && !found; i++) begin
                            if (live[i]) begin
                                if (pick < weights[i]) begin
                                    found = 1'b1;
                                    ans.status = ST_PICKED;
                                    ans.id = ids[i];
                                    ans.slot = SLOT_W'(i);
                                    // only a positive quota counts down
                                    if (uses[i] != 0 && !uses[i][LIM_W-1]) begin
                                        uses[i] = uses[i] - 1'b1;
                                        if (uses[i] == 0) begin
                                            live[i] = 1'b0;
                                            live_total = (live_total >= weights[i]) ?
                                                         live_total - weights[i] : '0;
                                        end
                                    end
                                end else begin
                                    pick -= weights[i];
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            ans.total = live_total;
            owed_picks = {owed_picks, ans};
        endfunction

        task check_pick(input logic [ST_W-1:0] status, input logic [ID_W-1:0] id,
                        input logic [SLOT_W-1:0] slot, input logic [TOT_W-1:0] total);
            pick_t want;
            if (owed_picks.size() == 0) begin
                report($sformatf("result beat with nothing owed, status %0d", status));
                return;
            end
            want = owed_picks.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, wanted %0d", status, want.status));
            if (id !== want.id)
                report($sformatf("chosen_id %0d, wanted %0d", id, want.id));
            if (slot !== want.slot)
                report($sformatf("chosen_slot %0d, wanted %0d", slot, want.slot));
            if (total !== want.total)
                report($sformatf("remaining_total %0d, wanted %0d", total, want.total));
        endtask

        task drain();
            pick_t want;
            while (owed_picks.size() > 0) begin
                want = owed_picks.pop_front();
                report($sformatf("no result for owed status %0d", want.status));
            end
        endtask
    endclass

    quota_wheel_sb sb;
    bit            loaded [ENTRIES];
    bit            steady = 1'b0;
    int unsigned   counted = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_pick(o_status, o_chosen_id, o_chosen_slot, o_remaining_total);
        end
    end

    // start stays high on return; the caller either sends again or paces
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                             input logic [ID_W-1:0] id, input logic [WGT_W-1:0] wgt,
                             input logic [LIM_W-1:0] lim, input logic [RND_W-1:0] rnd);
        start <= 1'b1;
        i_operation <= op;
        i_slot_index <= idx;
        i_entry_id <= id;
        i_entry_weight <= wgt;
        i_entry_max_uses <= lim;
        i_random_word <= rnd;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_item(op, idx, id, wgt, lim, rnd);
        if (op == OP_LOAD) loaded[idx] = 1'b1;
    endtask

    // unused fields get random values
    task automatic send_op(input logic [OP_W-1:0] op, input logic [RND_W-1:0] rnd);
        send_item(op, SLOT_W'($urandom), ID_W'($urandom), WGT_W'($urandom),
                  LIM_W'($urandom), rnd);
    endtask

    task automatic load_random(input logic [SLOT_W-1:0] idx);
        logic [WGT_W-1:0] wgt;
        logic [LIM_W-1:0] lim;
        case ($urandom_range(0, 9))
            0:       wgt = '0;
            1:       wgt = '1;
            2, 3, 4: wgt = WGT_W'($urandom_range(1, 15));
            default: wgt = WGT_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       lim = LIM_FOREVER;
            1:       lim = '0;
            2, 3, 4: lim = LIM_W'($urandom_range(1, 3));
            5:       lim = LIM_W'(1023);
            6:       lim = LIM_W'($urandom_range(1024, 2046));
            default: lim = LIM_W'($urandom);
        endcase
        send_item(OP_LOAD, idx, ID_W'($urandom), wgt, lim, $urandom);
    endtask

    task automatic pace();
        int gap;
        if (!steady && $urandom_range(0, 99) < 26) begin
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(5, 45);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.set_config(addr, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : main
        int span;
        int live_n;
        int burst;
        int roll;
        logic [RND_W-1:0] word;
        sb = new();
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table with default answer, then the unused operation
        send_op(OP_DRAW, $urandom);
        pace();
        send_item(OP_SPARE, '1, '1, '1, '1, '1);
        settle();
        write_reg(ADDR_EMPTY_DEF, 32'd0);
        send_op(OP_DRAW, '1);
        pace();
        send_item(OP_LOAD, 4'd0, 10'd1023, 12'd4095, LIM_FOREVER, '0);
        send_item(OP_LOAD, 4'd1, 10'd0, 12'd0, 11'd0, '1);
        send_item(OP_LOAD, 4'd2, 10'd5, 12'd1, 11'd1, '0);
        pace();
        send_item(OP_LOAD, 4'd3, 10'd512, 12'd4095, 11'd1023, '0);
        send_item(OP_LOAD, 4'd15, 10'h2AA, 12'hAAA, 11'h555, 32'h5555_5555);
        settle();
        write_reg(ADDR_ENTRIES, 32'd4);
        write_reg(ADDR_EMPTY_DEF, 32'd1);
        // nothing live yet: exhausted, not default
        send_op(OP_DRAW, 32'd7);
        send_op(OP_RESTART, '0);
        send_op(OP_DRAW, 32'd0);
        pace();
        send_op(OP_DRAW, 32'hFFFF_FFFF);
        // lands on the weight-one slot and retires it
        send_op(OP_DRAW, 32'd4095);
        send_op(OP_DRAW, 32'd4095);
        // shrinking a live weight leaves the walk with nowhere to land
        send_item(OP_LOAD, 4'd3, 10'd512, 12'd0, 11'd1, '0);
        send_op(OP_DRAW, 32'd8189);
        pace();
        send_item(OP_LOAD, 4'd3, 10'd512, 12'd4095, 11'd1, '0);
        send_item(OP_LOAD, 4'd0, 10'd1023, 12'd4095, 11'd1, '0);
        send_op(OP_RESTART, '1);
        send_item(OP_LOAD, 4'd2, 10'd6, 12'd4095, 11'd1, '0);
        send_op(OP_DRAW, 32'd4095);
        send_op(OP_DRAW, 32'd0);
        // retiring more weight than is left clamps the total at zero
        send_op(OP_DRAW, 32'd0);
        send_op(OP_DRAW, 32'd0);

        for (int phase = 0; counted < RANDOM_ITEMS; phase++) begin
            settle();
            case (phase)
                0:       span = ENTRIES;
                1:       span = 0;
                2:       span = 31;
                default: span = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                            : $urandom_range(0, 16);
            endcase
            write_reg(ADDR_ENTRIES, PDATA_W'(span));
            write_reg(ADDR_EMPTY_DEF, (phase == 1) ? 32'd1 : PDATA_W'($urandom_range(0, 1)));
            live_n = (span > ENTRIES) ? ENTRIES : span;
            // every slot a restart takes in must hold something
            for (int s = 0; s < ENTRIES; s++) begin
                if ((s < live_n && !loaded[s]) || $urandom_range(0, 3) == 0) begin
                    load_random(SLOT_W'(s));
                    pace();
                    counted++;
                end
            end
            send_op(OP_RESTART, $urandom);
            pace();
            counted++;
            burst = $urandom_range(30, 70);
            repeat (burst) begin
                steady = (counted >= 300 && counted < 450);
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    case ($urandom_range(0, 19))
                        0:       word = '0;
                        1:       word = '1;
                        2:       word = RND_W'($urandom_range(0, 255));
                        default: word = $urandom;
                    endcase
                    send_op(OP_DRAW, word);
                    counted++;
                end else if (roll < 88) begin
                    load_random(SLOT_W'($urandom));
                    counted++;
                end else if (roll < 95) begin
                    send_op(OP_RESTART, $urandom);
                    counted++;
                end else begin
                    send_op(OP_SPARE, $urandom);
                end
                pace();
            end
            steady = 1'b0;
        end

        start <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < 5000 && sb.pending() > 0; w++) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        sb.drain();
        if (sb.mismatches == 0) begin
            $display("PASS weighted_pick_with_use_quotas");
        end else begin
            $display("FAIL weighted_pick_with_use_quotas");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL weighted_pick_with_use_quotas");
        $finish;
    end

endmodule
